// ===== sv/tmcw_pkg.sv =====
package tmcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int CNT_W      = $clog2(CELL_COUNT + 1);

	localparam int ACTION_W = 2;
	localparam int CODE_W   = 8;
	localparam int ROW_W    = 5;
	localparam int COL_W    = 7;
	localparam int ATTR_W   = 8;
	localparam int CELL_W   = 16;
	localparam int TAB_STOP = 8;

	localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

	localparam logic [CODE_W-1:0] CODE_TAB     = 8'd9;
	localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'd10;
	localparam logic [CODE_W-1:0] CODE_RETURN  = 8'd13;
	localparam logic [CODE_W-1:0] CODE_SPACE   = 8'd32;

	localparam logic [ATTR_W-1:0] RESET_ATTR  = 8'h07;
	localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_ATTR, CODE_SPACE};

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [CODE_W-1:0]   char_code;
		logic [ROW_W-1:0]    read_row;
		logic [COL_W-1:0]    read_col;
	} req_t;

	typedef struct packed {
		logic [ROW_W-1:0]  cursor_row;
		logic [COL_W-1:0]  cursor_col;
		logic [CELL_W-1:0] cell_value;
		logic              scrolled;
	} res_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
		input logic [COL_W-1:0] c);
		return ADDR_W'(r * COLUMNS + c);
	endfunction

endpackage

// ===== sv/tmcw_req_if.sv =====
interface tmcw_req_if import tmcw_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [CODE_W-1:0]   char_code;
	logic [ROW_W-1:0]    read_row;
	logic [COL_W-1:0]    read_col;

	modport source (output valid, action, char_code, read_row, read_col, input ready);
	modport sink (input valid, action, char_code, read_row, read_col, output ready);
endinterface

// ===== sv/tmcw_rsp_if.sv =====
interface tmcw_rsp_if import tmcw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ROW_W-1:0]  cursor_row;
	logic [COL_W-1:0]  cursor_col;
	logic [CELL_W-1:0] cell_value;
	logic              scrolled;

	modport source (output valid, cursor_row, cursor_col, cell_value, scrolled, input ready);
	modport sink (input valid, cursor_row, cursor_col, cell_value, scrolled, output ready);
endinterface

// ===== sv/tmcw_cfg_if.sv =====
interface tmcw_cfg_if import tmcw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ATTR_W-1:0] text_attribute;

	modport source (output valid, text_attribute, input ready);
	modport sink (input valid, text_attribute, output ready);
endinterface

// ===== sv/tmcw_ram.sv =====
module tmcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/tmcw_ctrl.sv =====
module tmcw_ctrl import tmcw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  req_t              req,
	input  logic [ATTR_W-1:0] attr,
	input  logic              slot_free,
	output logic              push,
	output res_t              res
);

	typedef enum logic [2:0] {
		ST_INIT, ST_IDLE, ST_READ, ST_FILL, ST_COPY, ST_BLANK, ST_DONE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	res_t             res_q;

	logic [COL_W:0]      col_nx;
	logic [ROW_W:0]      row_nx;
	logic                printable;
	logic                put_scroll;
	logic                read_ok;
	logic [CELL_W-1:0]   blank;
	logic                we;
	logic [ADDR_W-1:0]   waddr;
	logic [ADDR_W-1:0]   raddr;
	logic [CELL_W-1:0]   wdata;
	logic [CELL_W-1:0]   rdata;

	assign blank     = {attr, CODE_SPACE};
	assign req_ready = (state_q == ST_IDLE);
	assign push      = (state_q == ST_DONE) && slot_free;
	assign res       = res_q;
	assign read_ok   = (int'(req.read_row) < ROWS) && (int'(req.read_col) < COLUMNS);

	// Cursor update for a put transaction, including wrap and scroll detection.
	always_comb begin
		col_nx    = {1'b0, col_q};
		row_nx    = {1'b0, row_q};
		printable = 1'b0;
		case (req.char_code)
			CODE_NEWLINE: begin
				col_nx = '0;
				row_nx = {1'b0, row_q} + 1'b1;
			end
			CODE_RETURN: begin
				col_nx = '0;
			end
			CODE_TAB: begin
				col_nx = ({1'b0, col_q} + (COL_W+1)'(TAB_STOP)) & ~(COL_W+1)'(TAB_STOP - 1);
			end
			default: begin
				printable = 1'b1;
				col_nx    = {1'b0, col_q} + 1'b1;
			end
		endcase
		if (int'(col_nx) >= COLUMNS) begin
			col_nx = '0;
			row_nx = row_nx + 1'b1;
		end
		put_scroll = int'(row_nx) >= ROWS;
	end

	// Memory port control. The sweep counter addresses every bulk pass.
	always_comb begin
		we    = 1'b0;
		waddr = cnt_q[ADDR_W-1:0];
		wdata = blank;
		raddr = cnt_q[ADDR_W-1:0];
		case (state_q)
			ST_INIT: begin
				we    = 1'b1;
				wdata = RESET_BLANK;
			end
			ST_IDLE: begin
				raddr = cell_addr(req.read_row, req.read_col);
				if (req_valid && req.action == ACT_PUT && printable) begin
					we    = 1'b1;
					waddr = cell_addr(row_q, col_q);
					wdata = {attr, req.char_code};
				end
			end
			ST_FILL, ST_BLANK: begin
				we = 1'b1;
			end
			ST_COPY: begin
				// Data read in the previous cycle lands one row up.
				we    = int'(cnt_q) > COLUMNS;
				waddr = ADDR_W'(cnt_q - CNT_W'(COLUMNS + 1));
				wdata = rdata;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	tmcw_ram #(.WIDTH(CELL_W), .DEPTH(CELL_COUNT)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			cnt_q   <= '0;
			row_q   <= '0;
			col_q   <= '0;
			res_q   <= '0;
		end else begin
			case (state_q)
				ST_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(CELL_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						case (req.action)
							ACT_PUT: begin
								if (put_scroll) begin
									row_q   <= ROW_W'(ROWS - 1);
									col_q   <= col_nx[COL_W-1:0];
									cnt_q   <= CNT_W'(COLUMNS);
									state_q <= ST_COPY;
								end else begin
									row_q   <= row_nx[ROW_W-1:0];
									col_q   <= col_nx[COL_W-1:0];
									res_q   <= '{row_nx[ROW_W-1:0], col_nx[COL_W-1:0], '0, 1'b0};
									state_q <= ST_DONE;
								end
							end
							ACT_CLEAR: begin
								row_q   <= '0;
								col_q   <= '0;
								cnt_q   <= '0;
								state_q <= ST_FILL;
							end
							ACT_READ: begin
								if (read_ok) begin
									state_q <= ST_READ;
								end else begin
									res_q   <= '{row_q, col_q, '0, 1'b0};
									state_q <= ST_DONE;
								end
							end
							default: begin
								res_q   <= '{row_q, col_q, '0, 1'b0};
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_READ: begin
					res_q   <= '{row_q, col_q, rdata, 1'b0};
					state_q <= ST_DONE;
				end
				ST_FILL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(CELL_COUNT - 1)) begin
						res_q   <= '{'0, '0, '0, 1'b0};
						state_q <= ST_DONE;
					end
				end
				ST_COPY: begin
					if (cnt_q == CNT_W'(CELL_COUNT)) begin
						cnt_q   <= CNT_W'(CELL_COUNT - COLUMNS);
						state_q <= ST_BLANK;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_BLANK: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(CELL_COUNT - 1)) begin
						res_q   <= '{row_q, col_q, '0, 1'b1};
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/text_mode_console_writer_core.sv =====
// Text console engine: a ROWS x COLUMNS store of 16-bit cells (attribute in the high byte)
// with a cursor. After reset the block sweeps the whole store to blank cells (space, attribute
// 0x07), one cell per clock, so req.ready stays low until the sweep ends;
// attribute writes on cfg are taken at any time. Each request is then handled alone by one
// sequencer and one sweep counter driving a single-write, single-read cell memory. A clear
// blanks every cell, and a put that scrolls makes one copy pass that moves each row up by
// one, then blanks the bottom row in the current attribute. A result register lets the
// next request in while the last result waits on rsp.
module text_mode_console_writer_core import tmcw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	tmcw_req_if.sink    req,
	tmcw_rsp_if.source  rsp,
	tmcw_cfg_if.sink    cfg
);

	logic [ATTR_W-1:0] attr_q;
	logic              out_valid_q;
	res_t              out_q;
	logic              slot_free;
	logic              push;
	logic              req_ready;
	req_t              req_item;
	res_t              res;

	assign cfg.ready = 1'b1;
	assign slot_free = !out_valid_q || rsp.ready;
	assign req.ready = req_ready;
	assign req_item  = '{req.action, req.char_code, req.read_row, req.read_col};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= RESET_ATTR;
		end else if (cfg.valid) begin
			attr_q <= cfg.text_attribute;
		end
	end

	tmcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.req       (req_item),
		.attr      (attr_q),
		.slot_free (slot_free),
		.push      (push),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= res;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.cursor_row = out_q.cursor_row;
	assign rsp.cursor_col = out_q.cursor_col;
	assign rsp.cell_value = out_q.cell_value;
	assign rsp.scrolled   = out_q.scrolled;

	// A transaction occupies the sequencer, so it is never ready right after one.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while a previous one is in progress");

	// A reported cursor always lies on the screen.
	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (int'(rsp.cursor_row) < ROWS && int'(rsp.cursor_col) < COLUMNS))
		else $error("cursor outside the screen");

	// A scroll leaves the cursor on the bottom row.
	a_scroll_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.scrolled) |-> (rsp.cursor_row == ROW_W'(ROWS - 1)))
		else $error("scroll did not leave the cursor on the bottom row");

	// A new result never overwrites one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |=> (rsp.valid && $stable(out_q)))
		else $error("pending result lost");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb import tmcw_pkg::*; ();

	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 20000;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 100;
	localparam int DRAIN_CYCLES = 20;

	typedef enum int {
		K_CHAR, K_NEWLINE, K_RETURN, K_TAB, K_READ, K_READ_WILD, K_CLEAR, K_UNUSED
	} item_kind_t;

	// Mirrors the screen store and cursor, and keeps the results still owed by the block.
	class console_model_t;
		logic [CELL_W-1:0] cells [CELL_COUNT];
		int                row;
		int                col;
		logic [ATTR_W-1:0] text_attr;
		res_t              expected_results [$];
		int                errors;

		function new();
			text_attr = RESET_ATTR;
			row = 0;
			col = 0;
			errors = 0;
			blank_all();
		endfunction

		function void blank_all();
			foreach (cells[i])
				cells[i] = {text_attr, CODE_SPACE};
		endfunction

		function void scroll_up();
			for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
				cells[i] = cells[i + COLUMNS];
			for (int x = 0; x < COLUMNS; x++)
				cells[CELL_COUNT - COLUMNS + x] = {text_attr, CODE_SPACE};
			row = ROWS - 1;
		endfunction

		function bit put_code(logic [CODE_W-1:0] code);
			if (code == CODE_NEWLINE) begin
				col = 0;
				row++;
			end else if (code == CODE_RETURN) begin
				col = 0;
			end else if (code == CODE_TAB) begin
				col = (col + TAB_STOP) & ~(TAB_STOP - 1);
			end else begin
				cells[row * COLUMNS + col] = {text_attr, code};
				col++;
			end
			if (col >= COLUMNS) begin
				col = 0;
				row++;
			end
			if (row >= ROWS) begin
				scroll_up();
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_request(req_t r);
			res_t want;
			want = '0;
			case (r.action)
				ACT_PUT: begin
					want.scrolled = put_code(r.char_code);
				end
				ACT_CLEAR: begin
					blank_all();
					row = 0;
					col = 0;
				end
				ACT_READ: begin
					if (r.read_row < ROWS && r.read_col < COLUMNS)
						want.cell_value = cells[r.read_row * COLUMNS + r.read_col];
				end
				default: ;
			endcase
			want.cursor_row = ROW_W'(row);
			want.cursor_col = COL_W'(col);
			expected_results.push_back(want);
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(res_t got);
			res_t want;
			if (expected_results.size() == 0) begin
				report($sformatf("unexpected result row %0d col %0d", got.cursor_row,
					got.cursor_col));
			end else begin
				want = expected_results.pop_front();
				if (got.cursor_row !== want.cursor_row)
					report($sformatf("cursor_row got %0d want %0d", got.cursor_row,
						want.cursor_row));
				if (got.cursor_col !== want.cursor_col)
					report($sformatf("cursor_col got %0d want %0d", got.cursor_col,
						want.cursor_col));
				if (got.cell_value !== want.cell_value)
					report($sformatf("cell_value got %h want %h", got.cell_value,
						want.cell_value));
				if (got.scrolled !== want.scrolled)
					report($sformatf("scrolled got %b want %b", got.scrolled, want.scrolled));
			end
		endtask
	endclass

	logic           clk;
	logic           arst_n;
	bit             calm;
	int             quiet_cycles = 0;
	console_model_t model;

	tmcw_req_if req_if ();
	tmcw_rsp_if rsp_if ();
	tmcw_cfg_if cfg_if ();

	text_mode_console_writer_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		rsp_if.ready <= calm || ($urandom_range(99) >= 33);
	end

	always @(posedge clk) begin
		res_t got;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got.cursor_row = rsp_if.cursor_row;
			got.cursor_col = rsp_if.cursor_col;
			got.cell_value = rsp_if.cell_value;
			got.scrolled   = rsp_if.scrolled;
			model.check_result(got);
		end
	end

	// The reset sweep, a clear and a scroll all hold the channels still while they pass
	// over the store, so the limit sits well above the length of a full sweep.
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
			(cfg_if.valid && cfg_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic req_t make_req(logic [ACTION_W-1:0] a, logic [CODE_W-1:0] c,
		logic [ROW_W-1:0] rr, logic [COL_W-1:0] rc);
		req_t r;
		r.action    = a;
		r.char_code = c;
		r.read_row  = rr;
		r.read_col  = rc;
		return r;
	endfunction

	function automatic req_t random_item(bit scroll_heavy);
		req_t       r;
		int         pick;
		item_kind_t kind;
		r.action    = ACT_PUT;
		r.char_code = CODE_W'($urandom_range(255));
		r.read_row  = ROW_W'($urandom_range(31));
		r.read_col  = COL_W'($urandom_range(127));
		pick = $urandom_range(99);
		// The scroll-heavy mix has no clears, so the cursor reaches the bottom row.
		if (scroll_heavy) begin
			if (pick < 55)
				kind = K_CHAR;
			else if (pick < 85)
				kind = K_NEWLINE;
			else if (pick < 88)
				kind = K_TAB;
			else if (pick < 98)
				kind = K_READ;
			else
				kind = K_UNUSED;
		end else begin
			if (pick < 58)
				kind = K_CHAR;
			else if (pick < 64)
				kind = K_NEWLINE;
			else if (pick < 67)
				kind = K_RETURN;
			else if (pick < 73)
				kind = K_TAB;
			else if (pick < 88)
				kind = K_READ;
			else if (pick < 92)
				kind = K_READ_WILD;
			else if (pick < 95)
				kind = K_CLEAR;
			else
				kind = K_UNUSED;
		end
		case (kind)
			K_NEWLINE: r.char_code = CODE_NEWLINE;
			K_RETURN:  r.char_code = CODE_RETURN;
			K_TAB:     r.char_code = CODE_TAB;
			K_READ: begin
				r.action   = ACT_READ;
				r.read_row = ROW_W'($urandom_range(ROWS - 1));
				r.read_col = COL_W'($urandom_range(COLUMNS - 1));
			end
			K_READ_WILD: r.action = ACT_READ;
			K_CLEAR:     r.action = ACT_CLEAR;
			K_UNUSED:    r.action = ACT_UNUSED;
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_item(input req_t r);
		while (!calm && $urandom_range(99) < 33) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid     <= 1'b1;
		req_if.action    <= r.action;
		req_if.char_code <= r.char_code;
		req_if.read_row  <= r.read_row;
		req_if.read_col  <= r.read_col;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		model.note_request(r);
	endtask

	// The request channel is held idle until every owed result has come back.
	task automatic write_attribute(input logic [ATTR_W-1:0] value);
		req_if.valid <= 1'b0;
		while (model.pending() != 0)
			@(posedge clk);
		cfg_if.valid          <= 1'b1;
		cfg_if.text_attribute <= value;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		cfg_if.valid <= 1'b0;
		model.text_attr = value;
	endtask

	initial begin
		logic [ATTR_W-1:0] attr;
		model = new();
		arst_n                = 1'b0;
		calm                  = 1'b0;
		req_if.valid          = 1'b0;
		req_if.action         = ACT_PUT;
		req_if.char_code      = '0;
		req_if.read_row       = '0;
		req_if.read_col       = '0;
		rsp_if.ready          = 1'b0;
		cfg_if.valid          = 1'b0;
		cfg_if.text_attribute = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset contents, the far corner and reads past each edge, then puts of each code kind, an unused action and a clear.
		send_item(make_req(ACT_READ, 8'd0, 5'd0, 7'd0));
		send_item(make_req(ACT_READ, 8'd0, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1)));
		send_item(make_req(ACT_READ, 8'd0, ROW_W'(ROWS), 7'd0));
		send_item(make_req(ACT_READ, 8'd0, 5'd31, 7'd127));
		send_item(make_req(ACT_READ, 8'd0, 5'd0, COL_W'(COLUMNS)));
		send_item(make_req(ACT_PUT, 8'h41, 5'd0, 7'd0));
		send_item(make_req(ACT_PUT, 8'h00, 5'd31, 7'd127));
		send_item(make_req(ACT_PUT, 8'hFF, 5'd0, 7'd0));
		send_item(make_req(ACT_PUT, CODE_TAB, 5'd0, 7'd0));
		send_item(make_req(ACT_PUT, CODE_RETURN, 5'd0, 7'd0));
		send_item(make_req(ACT_PUT, CODE_NEWLINE, 5'd0, 7'd0));
		send_item(make_req(ACT_UNUSED, 8'hFF, 5'd31, 7'd127));
		send_item(make_req(ACT_READ, 8'd0, 5'd0, 7'd0));
		send_item(make_req(ACT_READ, 8'd0, 5'd0, 7'd2));
		send_item(make_req(ACT_CLEAR, 8'd0, 5'd0, 7'd0));
		// Ten tabs from column 0 run off the last column and wrap.
		for (int i = 0; i < 10; i++)
			send_item(make_req(ACT_PUT, CODE_TAB, 5'd0, 7'd0));

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase == 0)
				attr = 8'h00;
			else if (phase == 1)
				attr = 8'hFF;
			else
				attr = ATTR_W'($urandom_range(255));
			write_attribute(attr);
			calm <= (phase == 5);
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_item(random_item(phase % 4 == 2));
		end

		req_if.valid <= 1'b0;
		calm         <= 1'b0;
		while (model.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (model.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
